// ===== src/ttn_pkg.sv =====
`default_nettype none

package ttn_pkg;

	localparam int FIELD_BITS     = 16;
	localparam int OUT_BITS       = 16;
	localparam int VTX_FIELDS     = 5;
	localparam int AXES           = 3;
	localparam int CORNERS        = 3;

	// field order inside a vertex
	localparam int F_X            = 0;
	localparam int F_Y            = 1;
	localparam int F_Z            = 2;
	localparam int F_U            = 3;
	localparam int F_V            = 4;

	localparam int UNIT_Q14       = 16384;
	localparam int UNIT_SHIFT     = 14;
	localparam int MAG_LIMIT_BITS = 30;

	localparam int MUL_W          = 31;
	localparam int PROD_W         = 2 * MUL_W;
	localparam int SQ_BITS        = 62;
	localparam int ROOT_BITS      = 31;
	localparam int ROOT_STEPS     = 31;
	localparam int RREM_BITS      = ROOT_BITS + 1;
	localparam int QUO_BITS       = 15;
	localparam int NUM_BITS       = MAG_LIMIT_BITS + UNIT_SHIFT + 1;
	localparam int ALU_W          = 64;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] tangent_x;
		logic signed [OUT_BITS-1:0] tangent_y;
		logic signed [OUT_BITS-1:0] tangent_z;
		logic                       degenerate;
	} ttn_res_t;

	typedef struct packed {
		logic signed [MUL_W-1:0] mul_a;
		logic signed [MUL_W-1:0] mul_b;
		logic signed [ALU_W-1:0] add_a;
		logic signed [ALU_W-1:0] add_b;
		logic                    sub;
	} ttn_alu_req_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
	} ttn_stat_t;

endpackage

`default_nettype wire

// ===== src/ttn_vtx_if.sv =====
`default_nettype none

interface ttn_vtx_if import ttn_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [FIELD_BITS-1:0] pos_x;
	logic signed [FIELD_BITS-1:0] pos_y;
	logic signed [FIELD_BITS-1:0] pos_z;
	logic signed [FIELD_BITS-1:0] tex_u;
	logic signed [FIELD_BITS-1:0] tex_v;

	modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

`default_nettype wire

// ===== src/ttn_tan_if.sv =====
`default_nettype none

interface ttn_tan_if import ttn_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] tangent_x;
	logic signed [OUT_BITS-1:0] tangent_y;
	logic signed [OUT_BITS-1:0] tangent_z;
	logic                       degenerate;

	modport source (output valid, tangent_x, tangent_y, tangent_z, degenerate, input ready);
	modport sink (input valid, tangent_x, tangent_y, tangent_z, degenerate, output ready);
endinterface

`default_nettype wire

// ===== src/ttn_alu.sv =====
`default_nettype none

// shared multiplier and adder/subtractor, operands picked by the sequencer
module ttn_alu import ttn_pkg::*; (
	input  ttn_alu_req_t              req,
	output logic signed [PROD_W-1:0]  prod,
	output logic signed [ALU_W-1:0]   sum
);

	assign prod = req.mul_a * req.mul_b;
	assign sum  = req.sub ? (req.add_a - req.add_b) : (req.add_a + req.add_b);

endmodule

`default_nettype wire

// ===== src/ttn_corner.sv =====
`default_nettype none

module ttn_corner import ttn_pkg::*; #(
	parameter  int COORD_BITS = 16,
	localparam int CW = (COORD_BITS <= FIELD_BITS) ? COORD_BITS : FIELD_BITS + 1,
	localparam int DW = CW + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [FIELD_BITS-1:0] field [VTX_FIELDS],
	output logic                  launch,
	output logic signed [DW-1:0]  d1 [VTX_FIELDS],
	output logic signed [DW-1:0]  d2 [VTX_FIELDS]
);

	logic [1:0]           count_q;
	logic signed [CW-1:0] held_q [2][VTX_FIELDS];
	logic signed [CW-1:0] cur [VTX_FIELDS];

	// fields are cut to COORD_BITS bits when that is 16 or fewer; a wider coordinate sees them as unsigned
	if (COORD_BITS <= FIELD_BITS) begin : g_narrow
		for (genvar i = 0; i < VTX_FIELDS; i++) begin : g_fld
			assign cur[i] = field[i][CW-1:0];
		end
	end else begin : g_wide
		for (genvar i = 0; i < VTX_FIELDS; i++) begin : g_fld
			assign cur[i] = {1'b0, field[i]};
		end
	end

	// a stray count of 3 also closes the triangle
	assign launch = take && (count_q >= 2'(CORNERS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int s = 0; s < 2; s++) begin
				for (int i = 0; i < VTX_FIELDS; i++) begin
					held_q[s][i] <= '0;
				end
			end
		end else if (take) begin
			if (launch) begin
				count_q <= '0;
			end else begin
				held_q[count_q[0]] <= cur;
				count_q <= count_q + 2'd1;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < VTX_FIELDS; i++) begin
			d1[i] = DW'(held_q[1][i]) - DW'(held_q[0][i]);
			d2[i] = DW'(cur[i]) - DW'(held_q[0][i]);
		end
	end

endmodule

`default_nettype wire

// ===== src/ttn_core.sv =====
`default_nettype none

module ttn_core import ttn_pkg::*; #(
	parameter  int COORD_BITS = 16,
	localparam int CW = (COORD_BITS <= FIELD_BITS) ? COORD_BITS : FIELD_BITS + 1,
	localparam int DW = CW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 launch,
	input  logic signed [DW-1:0] d1 [VTX_FIELDS],
	input  logic signed [DW-1:0] d2 [VTX_FIELDS],
	input  logic                 res_ready,
	output ttn_stat_t            stat,
	output ttn_res_t             res
);

	localparam int PW    = 2 * DW;
	localparam int TW    = PW + 1;
	localparam int MAGW  = (PW > MAG_LIMIT_BITS) ? PW : MAG_LIMIT_BITS;
	localparam int CNT_W = $clog2(ROOT_STEPS);
	localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(8);
	localparam logic [CNT_W-1:0] SQR_LAST  = CNT_W'(AXES);
	localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_BITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ABS,
		ST_SHIFT,
		ST_SQR,
		ST_ROOT,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [1:0]                k_q;
	logic signed [DW-1:0]      d1_q [VTX_FIELDS];
	logic signed [DW-1:0]      d2_q [VTX_FIELDS];
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [TW-1:0]      acc_q;
	logic signed [TW-1:0]      det_q;
	logic signed [TW-1:0]      t_q [AXES];
	logic [MAGW-1:0]           mag_q [AXES];
	logic [AXES-1:0]           neg_q;
	logic [SQ_BITS-1:0]        sumsq_q;
	logic [RREM_BITS-1:0]      rem_q;
	logic [ROOT_BITS-1:0]      r_q;
	logic [QUO_BITS-1:0]       numlo_q;
	logic [QUO_BITS-1:0]       q_q;
	ttn_res_t                  res_q;

	ttn_alu_req_t              req;
	logic signed [PROD_W-1:0]  prod;
	logic signed [ALU_W-1:0]   sum;

	logic [2:0]                j;
	logic [2:0]                p;
	logic [2:0]                kk;
	logic [1:0]                pk;
	logic [1:0]                sq_sel;
	logic signed [DW-1:0]      ma_d;
	logic signed [DW-1:0]      mb_d;
	logic signed [ALU_W-1:0]   acc_x;
	logic signed [ALU_W-1:0]   prod_x;
	logic [ROOT_BITS-1:0]      len;
	logic [RREM_BITS+1:0]      remsh;
	logic [ROOT_BITS+1:0]      trial;
	logic [RREM_BITS-1:0]      r2;
	logic [MAGW-1:0]           ormag;
	logic                      ge;
	logic [QUO_BITS-1:0]       qn;
	logic [QUO_BITS-1:0]       qc;
	logic signed [OUT_BITS-1:0] qs;

	ttn_alu u_alu (
		.req  (req),
		.prod (prod),
		.sum  (sum)
	);

	always_comb begin
		j      = cnt_q[2:0];
		p      = j - 3'd1;
		kk     = {1'b0, j[2:1] - 2'd1};
		pk     = p[2:1] - 2'd1;
		sq_sel = (cnt_q[1:0] == 2'd3) ? 2'd0 : cnt_q[1:0];
		acc_x  = ALU_W'(acc_q);
		prod_x = ALU_W'(prod_q);
		len    = (r_q == '0) ? ROOT_BITS'(1) : r_q;
		remsh  = {rem_q, sumsq_q[SQ_BITS-1 -: 2]};
		trial  = {r_q, 2'b01};
		r2     = {rem_q[RREM_BITS-2:0], numlo_q[QUO_BITS-1]};
		ormag  = mag_q[0] | mag_q[1] | mag_q[2];

		// product schedule: du1*dv2, du2*dv1, then dv2*e1[k], dv1*e2[k] per axis
		if (j == 3'd0) begin
			ma_d = d1_q[F_U];
			mb_d = d2_q[F_V];
		end else if (j == 3'd1) begin
			ma_d = d2_q[F_U];
			mb_d = d1_q[F_V];
		end else if (j[0]) begin
			ma_d = d1_q[F_V];
			mb_d = d2_q[kk];
		end else begin
			ma_d = d2_q[F_V];
			mb_d = d1_q[kk];
		end

		req = '0;
		unique case (state_q)
			ST_MUL: begin
				req.mul_a = MUL_W'(ma_d);
				req.mul_b = MUL_W'(mb_d);
				req.sub   = 1'b1;
				if (p == 3'd1 || !det_q[TW-1]) begin
					req.add_a = acc_x;
					req.add_b = prod_x;
				end else begin
					req.add_a = prod_x;
					req.add_b = acc_x;
				end
			end
			ST_SQR: begin
				req.mul_a = MUL_W'({1'b0, mag_q[sq_sel][MAG_LIMIT_BITS-1:0]});
				req.mul_b = MUL_W'({1'b0, mag_q[sq_sel][MAG_LIMIT_BITS-1:0]});
				req.add_a = ALU_W'(sumsq_q);
				req.add_b = prod_x;
			end
			ST_ROOT: begin
				req.add_a = ALU_W'(remsh);
				req.add_b = ALU_W'(trial);
				req.sub   = 1'b1;
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					req.add_a = ALU_W'({mag_q[k_q][MAG_LIMIT_BITS-1:0], {UNIT_SHIFT{1'b0}}});
					req.add_b = ALU_W'(len >> 1);
				end else begin
					req.add_a = ALU_W'(r2);
					req.add_b = ALU_W'(len);
					req.sub   = 1'b1;
				end
			end
			default: ;
		endcase

		ge = !sum[ALU_W-1];
		qn = {q_q[QUO_BITS-2:0], ge};
		qc = (qn > QUO_BITS'(UNIT_Q14)) ? QUO_BITS'(UNIT_Q14) : qn;
		qs = neg_q[k_q] ? -{1'b0, qc} : {1'b0, qc};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
			prod_q  <= '0;
			acc_q   <= '0;
			det_q   <= '0;
			neg_q   <= '0;
			sumsq_q <= '0;
			rem_q   <= '0;
			r_q     <= '0;
			numlo_q <= '0;
			q_q     <= '0;
			res_q   <= '0;
			for (int i = 0; i < VTX_FIELDS; i++) begin
				d1_q[i] <= '0;
				d2_q[i] <= '0;
			end
			for (int i = 0; i < AXES; i++) begin
				t_q[i]   <= '0;
				mag_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (launch) begin
						d1_q    <= d1;
						d2_q    <= d2;
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= prod;
					if (cnt_q != '0) begin
						if (p == 3'd1) begin
							det_q <= sum[TW-1:0];
						end else if (!p[0]) begin
							acc_q <= prod_q[TW-1:0];
						end else begin
							t_q[pk] <= sum[TW-1:0];
						end
					end
					if (cnt_q == MUL_LAST) begin
						state_q <= ST_ABS;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ABS: begin
					for (int i = 0; i < AXES; i++) begin
						neg_q[i] <= t_q[i][TW-1];
						mag_q[i] <= t_q[i][TW-1] ? MAGW'(-t_q[i]) : MAGW'(t_q[i]);
					end
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (det_q == '0 || ormag == '0) begin
						res_q   <= '{tangent_x: '0, tangent_y: '0, tangent_z: '0,
							degenerate: 1'b1};
						state_q <= ST_DONE;
					end else if ((ormag >> MAG_LIMIT_BITS) != '0) begin
						for (int i = 0; i < AXES; i++) begin
							mag_q[i] <= mag_q[i] >> 1;
						end
					end else begin
						sumsq_q <= '0;
						cnt_q   <= '0;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					prod_q <= prod;
					if (cnt_q != '0) begin
						sumsq_q <= sum[SQ_BITS-1:0];
					end
					if (cnt_q == SQR_LAST) begin
						rem_q   <= '0;
						r_q     <= '0;
						cnt_q   <= '0;
						state_q <= ST_ROOT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ROOT: begin
					// two radicand bits per step, trial divisor 4r+1
					sumsq_q <= sumsq_q << 2;
					if (ge) begin
						rem_q <= sum[RREM_BITS-1:0];
					end else begin
						rem_q <= remsh[RREM_BITS-1:0];
					end
					r_q <= {r_q[ROOT_BITS-2:0], ge};
					if (cnt_q == ROOT_LAST) begin
						cnt_q            <= '0;
						k_q              <= '0;
						res_q.degenerate <= 1'b0;
						state_q          <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						// numerator >> 15 is already below len, so 15 quotient bits remain
						rem_q   <= RREM_BITS'(sum[NUM_BITS-1:QUO_BITS]);
						numlo_q <= sum[QUO_BITS-1:0];
						q_q     <= '0;
						cnt_q   <= cnt_q + 1'b1;
					end else begin
						rem_q   <= ge ? sum[RREM_BITS-1:0] : r2;
						numlo_q <= numlo_q << 1;
						q_q     <= qn;
						if (cnt_q == DIV_LAST) begin
							unique case (k_q)
								2'd0:    res_q.tangent_x <= qs;
								2'd1:    res_q.tangent_y <= qs;
								default: res_q.tangent_z <= qs;
							endcase
							cnt_q <= '0;
							if (k_q == 2'(AXES - 1)) begin
								state_q <= ST_DONE;
							end else begin
								k_q <= k_q + 2'd1;
							end
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign stat.idle      = (state_q == ST_IDLE);
	assign stat.res_valid = (state_q == ST_DONE);
	assign res            = res_q;

endmodule

`default_nettype wire

// ===== src/triangle_tangent_normalize.sv =====
// Per-triangle tangent for normal mapping. Vertices arrive one per transaction, three
// to a triangle; the first two are stored, and the third starts a sequencer that runs
// the triangle's products, sums, square root and divides through one shared multiplier
// and one shared adder/subtractor. A non-degenerate triangle keeps the block busy
// (vertex.ready low) after its third vertex while the sequencer forms the products for
// the determinant and tangent, takes signs and magnitudes, makes 0 to 3 right shifts
// that bring the tangent magnitudes below 2^30, forms the sum of squares, runs 31
// one-step-per-cycle square root iterations and three restoring divides of 15 quotient
// bits each, and hands off the result. A degenerate triangle (zero determinant or zero
// tangent) returns with degenerate set and zero components. The result sits in an output
// register, so the next triangle's vertices are taken while it waits for tangent.ready.
`default_nettype none

module triangle_tangent_normalize import ttn_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ttn_vtx_if.sink     vertex,
	ttn_tan_if.source   tangent
);

	localparam int CW = (COORD_BITS <= FIELD_BITS) ? COORD_BITS : FIELD_BITS + 1;
	localparam int DW = CW + 1;

	logic                  take;
	logic                  launch;
	logic [FIELD_BITS-1:0] field [VTX_FIELDS];
	logic signed [DW-1:0]  d1 [VTX_FIELDS];
	logic signed [DW-1:0]  d2 [VTX_FIELDS];
	ttn_stat_t             stat;
	ttn_res_t              core_res;
	logic                  res_ready;
	logic                  tan_valid_q;
	ttn_res_t              tan_res_q;

	assign field[F_X] = vertex.pos_x;
	assign field[F_Y] = vertex.pos_y;
	assign field[F_Z] = vertex.pos_z;
	assign field[F_U] = vertex.tex_u;
	assign field[F_V] = vertex.tex_v;

	assign vertex.ready = stat.idle;
	assign take         = vertex.valid && vertex.ready;

	ttn_corner #(
		.COORD_BITS (COORD_BITS)
	) u_corner (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.field  (field),
		.launch (launch),
		.d1     (d1),
		.d2     (d2)
	);

	ttn_core #(
		.COORD_BITS (COORD_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.launch    (launch),
		.d1        (d1),
		.d2        (d2),
		.res_ready (res_ready),
		.stat      (stat),
		.res       (core_res)
	);

	assign res_ready = !tan_valid_q || tangent.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tan_valid_q <= 1'b0;
		end else if (stat.res_valid && res_ready) begin
			tan_valid_q <= 1'b1;
		end else if (tangent.ready) begin
			tan_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.res_valid && res_ready) begin
			tan_res_q <= core_res;
		end
	end

	assign tangent.valid      = tan_valid_q;
	assign tangent.tangent_x  = tan_res_q.tangent_x;
	assign tangent.tangent_y  = tan_res_q.tangent_y;
	assign tangent.tangent_z  = tan_res_q.tangent_z;
	assign tangent.degenerate = tan_res_q.degenerate;

	// third vertex must start the sequencer
	a_launch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		launch |=> !stat.idle)
		else $error("third vertex did not start the sequencer");

	// a finished triangle lands in the output register
	a_res_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.res_valid && res_ready) |=> tangent.valid)
		else $error("result handed off but output register empty");

	// the sequencer only leaves idle on a closing vertex
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(stat.idle) |-> $past(launch))
		else $error("sequencer started without a closing vertex");

endmodule

`default_nettype wire
